>>> hw/rtl/sts_pkg.sv
// Package for the sorted table search block: sizes, item kinds, transaction types
// and the command/status structs between controller and datapath. No dependencies.
`default_nettype none
package sts_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int KIND_W      = 2;
   localparam int POS_W       = 10;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
   } sts_req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
   } sts_rsp_type;

   typedef struct packed {
      logic clear;
      logic append;
      logic start_search;
      logic step_right;
      logic step_left;
      logic respond_hit;
      logic respond_miss;
   } sts_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic entry_lt;
      logic entry_eq;
      logic right_ok;
      logic left_ok;
   } sts_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/sorted_table_binary_search_top.sv
// Top level of the sorted table search block: controller plus datapath.
// Depends on sts_pkg, sts_ctrl, sts_dp (and sts_ram through sts_dp).
//
//   channel  handshake          payload
//   request  start / busy       req_item (sts_req_type: kind, value)
//   result   rsp_valid strobe   rsp_item (sts_rsp_type: found, position)
//
// Clear, append and ignored kinds are handled in idle. A search reads the RAM once
// per probe (about log2 of the fill count, at most 11 probes for 1024 entries) and
// registers the result strobe after the last compare; empty tables miss unprobed.
// Synchronous reset empties the table; no clearing pass. The receiver cannot stall.
`default_nettype none
module sorted_table_binary_search_top
   import sts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire sts_req_type req_item,
   output logic             rsp_valid,
   output sts_rsp_type      rsp_item
);

   sts_cmd_type    cmd;
   sts_status_type status;

   sts_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .kind   (req_item.kind),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sts_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .value     (req_item.value),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_item)
   );

endmodule
`default_nettype wire

>>> hw/rtl/sts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/sts_ctrl.sv
// Controller for the sorted table search: idle/probe state machine.
// Depends on sts_pkg.
`default_nettype none
module sts_ctrl
   import sts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [KIND_W-1:0] kind,
   input  wire sts_status_type    status,
   output sts_cmd_type            cmd,
   output logic                   busy
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PROBE = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (kind)
                  KIND_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  KIND_APPEND: begin
                     cmd.append = !status.count_full;
                  end
                  KIND_SEARCH: begin
                     if (status.count_zero) begin
                        cmd.respond_miss = 1'b1;
                     end else begin
                        cmd.start_search = 1'b1;
                        state_in         = ST_PROBE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (status.entry_eq) begin
               cmd.respond_hit = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.entry_lt) begin
               if (status.right_ok) begin
                  cmd.step_right = 1'b1;
               end else begin
                  cmd.respond_miss = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               if (status.left_ok) begin
                  cmd.step_left = 1'b1;
               end else begin
                  cmd.respond_miss = 1'b1;
                  state_in         = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

>>> hw/rtl/sts_dp.sv
// Datapath for the sorted table search: table RAM, fill count, search bounds,
// probe compare and result register. Depends on sts_pkg and sts_ram.
`default_nettype none
module sts_dp
   import sts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic signed [VALUE_W-1:0] value,
   input  wire sts_cmd_type           cmd,
   output sts_status_type             status,
   output logic                       rsp_valid,
   output sts_rsp_type                rsp
);

   localparam int SUM_W = CNT_W + 1;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          low_ff, low_in;
   logic [CNT_W-1:0]          high_ff, high_in;   // exclusive upper bound
   logic [ADDR_W-1:0]         mid_ff, mid_in;
   logic signed [VALUE_W-1:0] target_ff, target_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sts_rsp_type               rsp_ff, rsp_in;

   logic [VALUE_W-1:0] rd_data;
   logic               rd_en;
   logic [SUM_W-1:0]   first_sum, right_sum, left_sum;
   logic [CNT_W-1:0]   mid_ext, mid_plus;
   logic [31:0]        pos_wide;

   assign mid_ext   = CNT_W'(mid_ff);
   assign mid_plus  = mid_ext + CNT_W'(1);
   assign first_sum = SUM_W'(count_ff) - SUM_W'(1);
   assign right_sum = SUM_W'(mid_ext) + SUM_W'(high_ff);
   assign left_sum  = SUM_W'(low_ff) + SUM_W'(mid_ext) - SUM_W'(1);
   assign pos_wide  = 32'(mid_ff);

   assign status.count_zero = (count_ff == '0);
   assign status.count_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign status.entry_lt   = ($signed(rd_data) < target_ff);
   assign status.entry_eq   = ($signed(rd_data) == target_ff);
   assign status.right_ok   = (mid_plus < high_ff);
   assign status.left_ok    = (low_ff < mid_ext);

   assign rd_en = cmd.start_search | cmd.step_right | cmd.step_left;

   always_comb begin
      count_in     = count_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      target_in    = target_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.start_search) begin
         target_in = value;
         low_in    = '0;
         high_in   = count_ff;
         mid_in    = first_sum[ADDR_W:1];
      end
      if (cmd.step_right) begin
         low_in = mid_plus;
         mid_in = right_sum[ADDR_W:1];
      end
      if (cmd.step_left) begin
         high_in = mid_ext;
         mid_in  = left_sum[ADDR_W:1];
      end
      if (cmd.respond_hit) begin
         rsp_valid_in    = 1'b1;
         rsp_in.found    = 1'b1;
         rsp_in.position = pos_wide[POS_W-1:0];
      end
      if (cmd.respond_miss) begin
         rsp_valid_in    = 1'b1;
         rsp_in.found    = 1'b0;
         rsp_in.position = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   sts_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (value),
      .rd_en   (rd_en),
      .rd_addr (mid_in),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire
